### design/ev1527_pkg.sv
// ----------------------------------------------------------------------------
// ev1527_pkg
// Shared types and constants of the remote pulse decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ev1527_pkg;

	localparam int unsigned MAX_WIDTHS_DEF = 80;
	localparam int unsigned CODE_BITS      = 24;
	localparam int unsigned MIN_DECODE     = 50;
	localparam int unsigned SHORT_MUL      = 70;     // short tolerance, percent
	localparam int unsigned LONG_MUL       = 3 * 45; // long target 3x base, 45 percent
	localparam int unsigned SYNC_SHIFT     = 3;      // sync width >= 8x base
	localparam logic [15:0] NO_BASE        = 16'hFFFF;
	localparam int unsigned SYNC_ROOM      = 2 * CODE_BITS + 1;
	// floor(x / 100) == (x * DIV100_K) >> DIV100_SH, exact for x below 2^24
	localparam logic [25:0] DIV100_K       = 26'd42949673;
	localparam int unsigned DIV100_SH      = 32;

	localparam logic [15:0] RST_MIN_PULSE  = 16'd80;
	localparam logic [15:0] RST_FRAME_GAP  = 16'd5000;
	localparam logic [6:0]  RST_MIN_FRAME  = 7'd20;
	localparam logic [15:0] RST_MIN_BASE   = 16'd150;
	localparam logic [15:0] RST_REP_WIN    = 16'd350;
	localparam logic [23:0] RST_TARGET     = 24'd0;

	typedef enum logic [1:0] {
		ST_NEW    = 2'd0,
		ST_REPEAT = 2'd1,
		ST_FAIL   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_MIN_PULSE = 3'd0,
		CFG_FRAME_GAP = 3'd1,
		CFG_MIN_FRAME = 3'd2,
		CFG_MIN_BASE  = 3'd3,
		CFG_REP_WIN   = 3'd4,
		CFG_TARGET    = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic    edge_upd;
		logic    store;
		logic    cnt_clr;
		logic    close;
		logic    idx_clr;
		logic    idx_inc;
		logic    rd_en;
		logic    base_init;
		logic    base_upd;
		logic    tol_mul;
		logic    tol_div;
		logic    prev_ld;
		logic    a_ld;
		logic    bit_clr;
		logic    bit_shift;
		logic    commit;
		logic    out_load;
		status_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic gap_lt_min;
		logic gap_gt_frame;
		logic cnt_ge_min;
		logic cnt_full;
		logic n_lt_min;
		logic idx_last;
		logic base_none;
		logic sync_hit;
		logic room_bad;
		logic bit_ok;
		logic bits_done;
		logic is_repeat;
	} sts_t;

endpackage

`default_nettype wire

### design/ev1527_remote_pulse_decoder_unit.sv
// ----------------------------------------------------------------------------
// ev1527_remote_pulse_decoder_unit
// Measures receiver edge intervals, closes frames on a long gap and decodes
// the 24-bit remote code with repeat suppression.
// ----------------------------------------------------------------------------
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+----------------
//  in      | func, now_us, now_ms                      | in_valid/in_stall
//  out     | status, code, matches_target, frame_pulses| out_valid/out_stall
//  cfg     | cfg_index, cfg_data                       | cfg_valid/cfg_ready
//
//  An edge or poll word that closes no frame is taken without stalling input.
//  A closing word runs the decode sequencer over the single-port width
//  store: a base search over all widths, a search through the sync pair,
//  both widths of each data bit, then the fixed check, tolerance, repeat
//  and output steps.
//  Reset is asynchronous (arst_n low); no clearing pass is needed.
//  A finished word waits in the output register while input resumes; the
//  next decode waits only at its final step if that register is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module ev1527_remote_pulse_decoder_unit #(
	parameter int unsigned MAX_WIDTHS = ev1527_pkg::MAX_WIDTHS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        func,
	input  wire logic [31:0] now_us,
	input  wire logic [31:0] now_ms,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [23:0]      code,
	output logic             matches_target,
	output logic [6:0]       frame_pulses,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	ev1527_pkg::cmd_t cmd;
	ev1527_pkg::sts_t sts;

	// registers take a write in any cycle
	assign cfg_ready = 1'b1;

	ev1527_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ev1527_dp #(
		.MAX_WIDTHS (MAX_WIDTHS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.now_us         (now_us),
		.now_ms         (now_ms),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.status         (status),
		.code           (code),
		.matches_target (matches_target),
		.frame_pulses   (frame_pulses)
	);

	// a result only comes out of a decode, during which input is held off
	a_rise_from_decode: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a decode");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ev1527_pkg::ST_FAIL) |-> (code == '0 && !matches_target))
		else $error("failed frame carries code or match");

	a_match_new: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && matches_target) |-> (status == ev1527_pkg::ST_NEW))
		else $error("match flagged on non-new code");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ev1527_pkg::ST_NEW || status == ev1527_pkg::ST_REPEAT
			|| status == ev1527_pkg::ST_FAIL))
		else $error("bad status code");

endmodule

`default_nettype wire

### design/ev1527_dp.sv
// ----------------------------------------------------------------------------
// ev1527_dp
// Datapath: config registers, width store, counters, tolerance math, result.
// ----------------------------------------------------------------------------
`default_nettype none

module ev1527_dp #(
	parameter int unsigned MAX_WIDTHS = ev1527_pkg::MAX_WIDTHS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ev1527_pkg::cmd_t    cmd,
	output ev1527_pkg::sts_t         sts,
	input  wire logic [31:0]         now_us,
	input  wire logic [31:0]         now_ms,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [23:0]         cfg_data,
	output logic [1:0]               status,
	output logic [23:0]              code,
	output logic                     matches_target,
	output logic [6:0]               frame_pulses
);

	localparam int unsigned CNT_W = $clog2(MAX_WIDTHS + 1);
	localparam int unsigned AW    = $clog2(MAX_WIDTHS);
	localparam int unsigned CMPW  = (CNT_W > 7) ? CNT_W : 7;

	logic [15:0] min_pulse_q, frame_gap_q, min_base_q, rep_win_q;
	logic [6:0]  min_frame_q;
	logic [23:0] target_q;

	logic [31:0]      last_edge_q, last_ms_q, ms_q;
	logic [23:0]      last_code_q, code_q;
	logic [CNT_W-1:0] cnt_q, n_q, idx_q;
	logic [4:0]       bcnt_q;
	logic [15:0]      mem [MAX_WIDTHS];
	logic [15:0]      rdata_q, prev_q, a_q, base_q;
	logic [23:0]      sprod_q, lprod_q;
	logic [15:0]      stol_q;
	logic [16:0]      ltol_q;

	logic [31:0] gap, ms_diff;
	logic [49:0] sdiv, ldiv;
	logic [19:0] lng, s_lo, s_hi, l_lo, l_hi;
	logic        a_zero, a_one;

	function automatic logic near(input logic [15:0] v, input logic [19:0] lo,
		input logic [19:0] hi);
		logic [19:0] vx;
		vx = {4'd0, v};
		return (vx >= lo) && (vx <= hi);
	endfunction

	assign gap     = now_us - last_edge_q;
	assign ms_diff = ms_q - last_ms_q;
	assign sdiv    = 50'(sprod_q) * 50'(ev1527_pkg::DIV100_K);
	assign ldiv    = 50'(lprod_q) * 50'(ev1527_pkg::DIV100_K);
	assign lng     = 20'({base_q, 1'b0}) + 20'(base_q);
	assign s_lo    = 20'(base_q) - 20'(stol_q);
	assign s_hi    = 20'(base_q) + 20'(stol_q);
	assign l_lo    = lng - 20'(ltol_q);
	assign l_hi    = lng + 20'(ltol_q);
	assign a_zero  = near(a_q, s_lo, s_hi) && near(rdata_q, l_lo, l_hi);
	assign a_one   = near(a_q, l_lo, l_hi) && near(rdata_q, s_lo, s_hi);

	always_comb begin
		sts.gap_lt_min   = gap < {16'd0, min_pulse_q};
		sts.gap_gt_frame = gap > {16'd0, frame_gap_q};
		sts.cnt_ge_min   = CMPW'(cnt_q) >= CMPW'(min_frame_q);
		sts.cnt_full     = cnt_q == CNT_W'(MAX_WIDTHS);
		sts.n_lt_min     = n_q < CNT_W'(ev1527_pkg::MIN_DECODE);
		sts.idx_last     = ({1'b0, idx_q} + 1'b1) == {1'b0, n_q};
		sts.base_none    = base_q == ev1527_pkg::NO_BASE;
		sts.sync_hit     = (idx_q != '0) && near(prev_q, s_lo, s_hi)
			&& (20'(rdata_q) >= (20'(base_q) << ev1527_pkg::SYNC_SHIFT));
		sts.room_bad     = ({1'b0, idx_q} + (CNT_W + 1)'(ev1527_pkg::SYNC_ROOM))
			> {1'b0, n_q};
		sts.bit_ok       = a_zero || a_one;
		sts.bits_done    = bcnt_q == 5'(ev1527_pkg::CODE_BITS - 1);
		sts.is_repeat    = (code_q == last_code_q) && (ms_diff < {16'd0, rep_win_q});
	end

	// config and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_pulse_q <= ev1527_pkg::RST_MIN_PULSE;
			frame_gap_q <= ev1527_pkg::RST_FRAME_GAP;
			min_frame_q <= ev1527_pkg::RST_MIN_FRAME;
			min_base_q  <= ev1527_pkg::RST_MIN_BASE;
			rep_win_q   <= ev1527_pkg::RST_REP_WIN;
			target_q    <= ev1527_pkg::RST_TARGET;
			last_edge_q <= '0;
			last_ms_q   <= '0;
			last_code_q <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (ev1527_pkg::cfg_idx_t'(cfg_index))
					ev1527_pkg::CFG_MIN_PULSE: min_pulse_q <= cfg_data[15:0];
					ev1527_pkg::CFG_FRAME_GAP: frame_gap_q <= cfg_data[15:0];
					ev1527_pkg::CFG_MIN_FRAME: min_frame_q <= cfg_data[6:0];
					ev1527_pkg::CFG_MIN_BASE:  min_base_q  <= cfg_data[15:0];
					ev1527_pkg::CFG_REP_WIN:   rep_win_q   <= cfg_data[15:0];
					ev1527_pkg::CFG_TARGET:    target_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.edge_upd) last_edge_q <= now_us;
			if (cmd.store) cnt_q <= cnt_q + 1'b1;
			else if (cmd.cnt_clr || cmd.close) cnt_q <= '0;
			if (cmd.commit) begin
				last_code_q <= code_q;
				last_ms_q   <= ms_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store) mem[cnt_q[AW-1:0]] <= gap[15:0];
		if (cmd.rd_en) rdata_q <= mem[idx_q[AW-1:0]];
	end

	// decode working registers
	always_ff @(posedge clk) begin
		if (cmd.close) begin
			n_q    <= cnt_q;
			ms_q   <= now_ms;
			code_q <= '0;
		end
		if (cmd.idx_clr) idx_q <= '0;
		else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
		if (cmd.base_init) base_q <= ev1527_pkg::NO_BASE;
		else if (cmd.base_upd && rdata_q >= min_base_q && rdata_q < base_q)
			base_q <= rdata_q;
		if (cmd.tol_mul) begin
			sprod_q <= 24'(base_q) * 24'(ev1527_pkg::SHORT_MUL);
			lprod_q <= 24'(base_q) * 24'(ev1527_pkg::LONG_MUL);
		end
		if (cmd.tol_div) begin
			stol_q <= sdiv[ev1527_pkg::DIV100_SH +: 16];
			ltol_q <= ldiv[ev1527_pkg::DIV100_SH +: 17];
		end
		if (cmd.prev_ld) prev_q <= rdata_q;
		if (cmd.a_ld) a_q <= rdata_q;
		if (cmd.bit_clr) bcnt_q <= '0;
		else if (cmd.bit_shift) begin
			bcnt_q <= bcnt_q + 1'b1;
			code_q <= {code_q[22:0], ~a_zero};
		end
		if (cmd.out_load) begin
			status         <= cmd.out_sel;
			code           <= (cmd.out_sel == ev1527_pkg::ST_FAIL) ? '0 : code_q;
			matches_target <= (cmd.out_sel == ev1527_pkg::ST_NEW) && (target_q != '0)
				&& (code_q == target_q);
			frame_pulses   <= 7'(n_q);
		end
	end

endmodule

`default_nettype wire

### design/ev1527_ctrl.sv
// ----------------------------------------------------------------------------
// ev1527_ctrl
// Controller: input event handling and the frame decode sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module ev1527_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              func,
	output logic                   out_valid,
	input  wire logic              out_stall,
	input  wire ev1527_pkg::sts_t  sts,
	output ev1527_pkg::cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_CHK, S_MIN_RD, S_MIN_CMP, S_TOL_MUL, S_TOL_DIV, S_SYN_RD,
		S_SYN_CMP, S_BIT_RDA, S_BIT_A, S_BIT_RDB, S_BIT_B, S_REP, S_OUT
	} state_t;

	state_t               state_q;
	ev1527_pkg::status_t  sel_q;
	logic                 in_acc, out_free, do_close;

	assign in_stall = state_q != S_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	// close on a long gap with enough widths, by edge or poll alike
	assign do_close = sts.gap_gt_frame && sts.cnt_ge_min && (func || !sts.gap_lt_min);

	always_comb begin
		cmd         = '0;
		cmd.out_sel = sel_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd.edge_upd = !func;
					cmd.close    = do_close;
					if (!func && !sts.gap_lt_min) begin
						if (sts.gap_gt_frame) cmd.cnt_clr = !sts.cnt_ge_min;
						else if (sts.cnt_full) cmd.cnt_clr = 1'b1;
						else cmd.store = 1'b1;
					end
				end
			end
			S_CHK: begin
				cmd.base_init = 1'b1;
				cmd.idx_clr   = 1'b1;
			end
			S_MIN_RD: cmd.rd_en = 1'b1;
			S_MIN_CMP: begin
				cmd.base_upd = 1'b1;
				cmd.idx_inc  = 1'b1;
			end
			S_TOL_MUL: cmd.tol_mul = 1'b1;
			S_TOL_DIV: begin
				cmd.tol_div = 1'b1;
				cmd.idx_clr = 1'b1;
			end
			S_SYN_RD: cmd.rd_en = 1'b1;
			S_SYN_CMP: begin
				cmd.prev_ld = !sts.sync_hit;
				cmd.idx_inc = 1'b1;
				cmd.bit_clr = 1'b1;
			end
			S_BIT_RDA: cmd.rd_en = 1'b1;
			S_BIT_A: begin
				cmd.a_ld    = 1'b1;
				cmd.idx_inc = 1'b1;
			end
			S_BIT_RDB: cmd.rd_en = 1'b1;
			S_BIT_B: begin
				cmd.bit_shift = sts.bit_ok;
				cmd.idx_inc   = 1'b1;
			end
			S_REP: cmd.commit = !sts.is_repeat;
			S_OUT: cmd.out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sel_q     <= ev1527_pkg::ST_FAIL;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_OUT) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_acc && do_close) state_q <= S_CHK;
				S_CHK: begin
					if (sts.n_lt_min) begin
						sel_q   <= ev1527_pkg::ST_FAIL;
						state_q <= S_OUT;
					end else state_q <= S_MIN_RD;
				end
				S_MIN_RD: state_q <= S_MIN_CMP;
				S_MIN_CMP: state_q <= sts.idx_last ? S_TOL_MUL : S_MIN_RD;
				S_TOL_MUL: begin
					if (sts.base_none) begin
						sel_q   <= ev1527_pkg::ST_FAIL;
						state_q <= S_OUT;
					end else state_q <= S_TOL_DIV;
				end
				S_TOL_DIV: state_q <= S_SYN_RD;
				S_SYN_RD: state_q <= S_SYN_CMP;
				S_SYN_CMP: begin
					if (sts.sync_hit) begin
						if (sts.room_bad) begin
							sel_q   <= ev1527_pkg::ST_FAIL;
							state_q <= S_OUT;
						end else state_q <= S_BIT_RDA;
					end else if (sts.idx_last) begin
						sel_q   <= ev1527_pkg::ST_FAIL;
						state_q <= S_OUT;
					end else state_q <= S_SYN_RD;
				end
				S_BIT_RDA: state_q <= S_BIT_A;
				S_BIT_A: state_q <= S_BIT_RDB;
				S_BIT_RDB: state_q <= S_BIT_B;
				S_BIT_B: begin
					if (!sts.bit_ok) begin
						sel_q   <= ev1527_pkg::ST_FAIL;
						state_q <= S_OUT;
					end else state_q <= sts.bits_done ? S_REP : S_BIT_RDA;
				end
				S_REP: begin
					sel_q   <= sts.is_repeat ? ev1527_pkg::ST_REPEAT : ev1527_pkg::ST_NEW;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ev1527_remote_pulse_decoder_unit. Drives edge and
// poll words built from well-formed remote frames, flawed frames and noise,
// predicts every closed frame with its own decoder model and checks each
// result word field by field, under random idling and long receiver holds.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ev1527_pkg::*;

	localparam int          STORE_DEPTH = 80;
	localparam int          DRAIN_WAIT  = 700;     // outlasts the longest decode
	localparam int          CYCLE_LIMIT = 3000000;
	localparam int          ITEM_GOAL   = 1950;
	localparam int          RESULT_GOAL = 15;
	localparam logic [2:0]  CFG_SPARE_A = 3'd6;    // unmapped register indexes
	localparam logic [2:0]  CFG_SPARE_B = 3'd7;

	typedef struct packed {
		status_t     st;
		logic [23:0] code;
		logic        hit;
		logic [6:0]  pulses;
	} frame_res_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [31:0] now_us;
	logic [31:0] now_ms;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [23:0] code;
	logic        matches_target;
	logic [6:0]  frame_pulses;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	ev1527_remote_pulse_decoder_unit dut (.*);

	// decoder model state
	logic [15:0] m_widths [STORE_DEPTH];
	int unsigned m_count;
	logic [31:0] m_last_us;
	logic [23:0] m_last_code;
	logic [31:0] m_last_ms;
	logic [15:0] m_min_pulse, m_frame_gap, m_min_base, m_rep_win;
	logic [6:0]  m_min_frame;
	logic [23:0] m_target;

	frame_res_t  expected_frames [$];
	int          n_errors;
	int          n_words;
	int          n_frames_seen;
	bit          idle_on;
	bit          hold_req;
	logic [31:0] t_us;
	logic [31:0] t_ms;
	logic [23:0] recent_code;

	// ---------------------------------------------------------------- clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		int cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[ev1527_remote_pulse_decoder_unit] ERROR");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- model
	function automatic bit near_target(longint unsigned v, longint unsigned tgt,
			longint unsigned pct);
		longint unsigned tol;
		tol = (tgt * pct) / 100;
		return v >= tgt - tol && v <= tgt + tol;
	endfunction

	function automatic bit decode_widths(int unsigned n, output logic [23:0] c);
		longint unsigned base, a, b, lng;
		int unsigned sync, data;
		bit found;
		c = '0;
		base = NO_BASE;
		found = 0;
		sync = 0;
		if (n < MIN_DECODE || n > STORE_DEPTH)
			return 0;
		for (int i = 0; i < n; i++)
			if (m_widths[i] >= m_min_base && m_widths[i] < base)
				base = m_widths[i];
		if (base == NO_BASE)
			return 0;
		for (int i = 0; i + 1 < n; i++) begin
			if (near_target(m_widths[i], base, 70) && m_widths[i+1] >= base * 8) begin
				sync = i;
				found = 1;
				break;
			end
		end
		if (!found)
			return 0;
		data = sync + 2;
		if (data + 2 * CODE_BITS > n)
			return 0;
		lng = base * 3;
		for (int k = 0; k < CODE_BITS; k++) begin
			a = m_widths[data + 2*k];
			b = m_widths[data + 2*k + 1];
			c = c << 1;
			if (near_target(a, base, 70) && near_target(b, lng, 45)) begin
			end else if (near_target(a, lng, 45) && near_target(b, base, 70)) begin
				c[0] = 1'b1;
			end else begin
				return 0;
			end
		end
		return 1;
	endfunction

	function automatic frame_res_t close_capture(logic [31:0] ms);
		frame_res_t r;
		logic [23:0] c;
		int unsigned n;
		n = m_count;
		m_count = 0;
		r.pulses = n[6:0];
		r.hit = 1'b0;
		if (!decode_widths(n, c)) begin
			r.st = ST_FAIL;
			r.code = '0;
			return r;
		end
		r.code = c;
		if (c == m_last_code && (ms - m_last_ms) < {16'd0, m_rep_win}) begin
			r.st = ST_REPEAT;
			return r;
		end
		m_last_code = c;
		m_last_ms = ms;
		r.st = ST_NEW;
		r.hit = (m_target != 0 && c == m_target);
		return r;
	endfunction

	// one accepted word; returns 1 when a frame result is due
	function automatic bit model_word(logic f, logic [31:0] us, logic [31:0] ms,
			output frame_res_t r);
		logic [31:0] gap;
		r = '0;
		gap = us - m_last_us;
		if (f) begin
			if (m_count >= m_min_frame && gap > m_frame_gap) begin
				r = close_capture(ms);
				return 1;
			end
			return 0;
		end
		m_last_us = us;
		if (gap < m_min_pulse)
			return 0;
		if (gap > m_frame_gap) begin
			if (m_count >= m_min_frame) begin
				r = close_capture(ms);
				return 1;
			end
			m_count = 0;
			return 0;
		end
		if (m_count < STORE_DEPTH)
			m_widths[m_count++] = gap[15:0];
		else
			m_count = 0;
		return 0;
	endfunction

	function automatic void model_reg(logic [2:0] idx, logic [23:0] d);
		case (idx)
			CFG_MIN_PULSE: m_min_pulse = d[15:0];
			CFG_FRAME_GAP: m_frame_gap = d[15:0];
			CFG_MIN_FRAME: m_min_frame = d[6:0];
			CFG_MIN_BASE:  m_min_base  = d[15:0];
			CFG_REP_WIN:   m_rep_win   = d[15:0];
			CFG_TARGET:    m_target    = d;
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------- checker
	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0h want %0h (t=%0t)", what, got, want, $realtime);
		n_errors++;
	endtask

	always @(posedge clk) begin
		frame_res_t w;
		if (arst_n && out_valid && !out_stall) begin
			n_frames_seen++;
			if (expected_frames.size() == 0) begin
				report_mismatch("unexpected word, status", status, 0);
			end else begin
				w = expected_frames.pop_front();
				if (status !== w.st)            report_mismatch("status", status, w.st);
				if (code !== w.code)            report_mismatch("code", code, w.code);
				if (matches_target !== w.hit)   report_mismatch("match", matches_target, w.hit);
				if (frame_pulses !== w.pulses)  report_mismatch("pulses", frame_pulses, w.pulses);
			end
		end
	end

	// receiver: short random stalls, or one long hold on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (3000) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 0;
			end else if (idle_on && $urandom_range(0, 6) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- driving
	task automatic send_word(logic f, logic [31:0] us, logic [31:0] ms);
		frame_res_t r;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		now_us   <= us;
		now_ms   <= ms;
		do @(posedge clk); while (in_stall);
		n_words++;
		if (model_word(f, us, ms, r))
			expected_frames.push_back(r);
	endtask

	task automatic send_edge(int unsigned interval);
		t_us += interval;
		if ($urandom_range(0, 3) == 0)
			t_ms += 1;
		send_word(1'b0, t_us, t_ms);
	endtask

	task automatic send_poll(int unsigned interval);
		t_us += interval;
		send_word(1'b1, t_us, t_ms);
	endtask

	// sender pause: every expected word back, then decoder fully quiet
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [23:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		model_reg(idx, d);
	endtask

	task automatic configure(logic [15:0] mp, logic [15:0] fg, logic [6:0] mf,
			logic [15:0] mb, logic [15:0] rw, logic [23:0] tc);
		drain();
		write_reg(CFG_MIN_PULSE, {8'd0, mp});
		write_reg(CFG_FRAME_GAP, {8'd0, fg});
		write_reg(CFG_MIN_FRAME, {17'd0, mf});
		write_reg(CFG_MIN_BASE,  {8'd0, mb});
		write_reg(CFG_REP_WIN,   {8'd0, rw});
		write_reg(CFG_TARGET,    tc);
		if ($urandom_range(0, 1))
			write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one remote frame: leading gap, sync pair, 24 bit pairs.
	// flaw: 0 clean, 1 one width scrambled, 2 cut short, 3 glitch inside
	task automatic send_frame(logic [23:0] c, int unsigned base, int flaw, bit poll_close);
		int unsigned w [50];
		int unsigned cut;
		w[0] = base + $urandom_range(0, base / 10);
		w[1] = 8 * base + $urandom_range(0, 3 * base);
		for (int k = 0; k < CODE_BITS; k++) begin
			int unsigned sh, lg;
			sh = base + $urandom_range(0, base / 10);
			lg = 3 * base - base / 4 + $urandom_range(0, base / 2);
			w[2 + 2*k]     = c[23-k] ? lg : sh;
			w[2 + 2*k + 1] = c[23-k] ? sh : lg;
		end
		if (flaw == 1)
			w[$urandom_range(0, 49)] = $urandom_range(1, 6000);
		cut = (flaw == 2) ? $urandom_range(1, 49) : 50;
		send_edge(32'(m_frame_gap) + 1 + $urandom_range(0, 3000));
		for (int i = 0; i < cut; i++) begin
			if (flaw == 3 && i == 20 && m_min_pulse > 0)
				send_edge($urandom_range(0, m_min_pulse - 1));
			send_edge(w[i]);
		end
		if (poll_close) begin
			send_poll($urandom_range(0, 32'(m_frame_gap)));
			send_poll(32'(m_frame_gap) + 1 + $urandom_range(0, 2000));
		end
		t_ms += $urandom_range(0, 500);
	endtask

	// ---------------------------------------------------------------- tests
	task automatic test_default_frames();
		logic [23:0] c;
		c = $urandom;
		send_frame(c, 300, 0, 1);
		send_frame(c, 300, 0, 0);          // same code again: suppressed if inside the window
		t_ms += 1000;
		send_frame(c, 250, 0, 1);          // window passed: new again
		send_frame(24'hFFFFFF, 400, 0, 1);
		send_frame(24'h000000, 150, 0, 1);
	endtask

	task automatic test_capture_limits();
		// store overflow: more widths than the store holds
		send_edge(32'(m_frame_gap) + 100);
		repeat (STORE_DEPTH + 3) send_edge(200);
		send_poll(32'(m_frame_gap) + 1);
		// gap closes a capture that is too short to count
		repeat (5) send_edge(300);
		send_edge(32'(m_frame_gap) + 1);
		// enough to close but too few to decode
		repeat (30) send_edge(300);
		send_poll(32'(m_frame_gap) + 1);
		// glitch inside a frame, then a poll that finds no frame end
		send_frame($urandom, 300, 3, 0);
		send_poll(10);
		send_poll(32'(m_frame_gap) + 1);
	endtask

	task automatic test_counter_wrap();
		t_us = 32'hFFFF_F800;
		t_ms = 32'hFFFF_FFF0;
		send_frame(24'hA5A5A5, 300, 0, 1);
		send_frame(24'hA5A5A5, 300, 0, 1);
		send_frame(24'h5A5A5A, 300, 0, 1);
	endtask

	task automatic test_register_extremes();
		logic [23:0] c;
		c = $urandom | 24'h1;
		configure(16'd0, 16'd65535, 7'd0, 16'd0, 16'd0, c);
		send_frame(c, 300, 0, 1);          // target match, every code is new
		send_frame(c, 300, 0, 1);
		send_poll(16);                     // empty frames close on polls
		send_poll(70000);
		configure(16'd65535, 16'd0, 7'd127, 16'd65535, 16'd65535, 24'hFFFFFF);
		repeat (6) send_edge($urandom_range(0, 80000));
		send_poll(90000);
		configure(16'd80, 16'd5000, 7'd81, 16'd150, 16'd350, 24'd0);
		send_frame($urandom, 300, 0, 1);   // threshold above store never closes
		configure(16'd80, 16'd5000, 7'd50, 16'd65535, 16'd350, 24'd0);
		send_frame($urandom, 300, 0, 1);   // no usable base
		configure(16'd80, 16'd5000, 7'd1, 16'd150, 16'd65535, 24'd0);
		send_frame(24'h123456, 300, 0, 1);
		send_frame(24'h123456, 300, 0, 1);
	endtask

	task automatic test_backpressure();
		configure(16'd80, 16'd5000, 7'd20, 16'd150, 16'd0, 24'd0);
		idle_on = 0;
		hold_req = 1;
		repeat (4) send_frame($urandom, 300, 0, 1);
		drain();
		idle_on = 1;
	endtask

	task automatic random_traffic(int goal_words, int goal_frames);
		int start_w, start_f, sel;
		logic [23:0] c;
		start_w = n_words;
		start_f = n_frames_seen;
		while (n_words - start_w < goal_words || n_frames_seen - start_f < goal_frames) begin
			sel = $urandom_range(0, 19);
			c = ($urandom_range(0, 2) == 0) ? recent_code :
			    ($urandom_range(0, 3) == 0) ? m_target : 24'($urandom);
			recent_code = c;
			if (sel < 14)
				send_frame(c, $urandom_range(150, 400), 0, $urandom_range(0, 1));
			else if (sel < 17)
				send_frame(c, $urandom_range(150, 400), $urandom_range(1, 3), $urandom_range(0, 1));
			else
				repeat ($urandom_range(1, 10)) begin
					if ($urandom_range(0, 3) == 0)
						send_poll($urandom_range(0, 70000));
					else
						send_edge($urandom_range(0, 7000));
				end
		end
	endtask

	task automatic test_random();
		int per;
		// spread what is left of the word budget over the five sections
		per = (ITEM_GOAL - n_words) / 5;
		random_traffic(per, RESULT_GOAL / 5);
		configure(16'd100, 16'd6000, 7'd40, 16'd0, 16'd800, recent_code);
		random_traffic(per, RESULT_GOAL / 5);
		configure(16'd0, 16'd65535, 7'd50, 16'd120, 16'd65535, 24'($urandom));
		random_traffic(per, RESULT_GOAL / 5);
		configure(16'd150, 16'd5500, 7'd1, 16'd200, 16'd100, recent_code);
		random_traffic(per, RESULT_GOAL / 5);
		configure(16'd80, 16'd5000, 7'd20, 16'd150, 16'd350, 24'd0);
		drain();
		idle_on = 0;                       // closing stretch at full rate
		random_traffic(per, RESULT_GOAL / 5);
	endtask

	// ---------------------------------------------------------------- main
	initial begin
		arst_n    = 1'b0;
		in_valid  <= 1'b0;
		func      <= 1'b0;
		now_us    <= '0;
		now_ms    <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_MIN_PULSE;
		cfg_data  <= '0;
		n_errors = 0;
		n_words = 0;
		n_frames_seen = 0;
		idle_on = 1;
		hold_req = 0;
		t_us = 32'd1000;
		t_ms = 32'd0;
		recent_code = '0;
		m_count = 0;
		m_last_us = '0;
		m_last_code = '0;
		m_last_ms = '0;
		m_min_pulse = RST_MIN_PULSE;
		m_frame_gap = RST_FRAME_GAP;
		m_min_frame = RST_MIN_FRAME;
		m_min_base = RST_MIN_BASE;
		m_rep_win = RST_REP_WIN;
		m_target = RST_TARGET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_frames();
		test_capture_limits();
		test_counter_wrap();
		test_register_extremes();
		test_backpressure();
		test_random();

		drain();
		if (n_errors == 0)
			$display("[ev1527_remote_pulse_decoder_unit] OK");
		else
			$display("[ev1527_remote_pulse_decoder_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
design/ev1527_pkg.sv
design/ev1527_dp.sv
design/ev1527_ctrl.sv
design/ev1527_remote_pulse_decoder_unit.sv
bench/testbench.sv
